@@ rtl/extent_to_block_splitter_assert.svh @@
// Assertion macros for the extent to block splitter.
// Included by the top level; needs nothing else.
`ifndef EXTENT_TO_BLOCK_SPLITTER_ASSERT_SVH
`define EXTENT_TO_BLOCK_SPLITTER_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define ETS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("extent_to_block_splitter: assertion failed");

// Next-cycle implication, skipped while reset is high.
`define ETS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("extent_to_block_splitter: assertion failed");

`endif

@@ rtl/ets_pkg.sv @@
// Shared widths, register indexes, state types and structs of the extent splitter.
// Depends on nothing; every RTL module imports it.
`default_nettype none

package ets_pkg;

   // field widths
   localparam int BLOCK_SIZE_W = 27;
   localparam int CHUNK_SIZE_W = 32;
   localparam int FS_ID_W      = 32;
   localparam int INODE_W      = 64;
   localparam int CHUNK_NUM_W  = 64;
   localparam int COMPACTION_W = 32;
   localparam int OFFSET_W     = 48;
   localparam int LENGTH_W     = 32;
   localparam int INDEX_W      = 32;
   localparam int BYTES_W      = 27;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_SIZE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHUNK_SIZE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILESYSTEM_ID = 2'd2;

   localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RESET = 27'd4194304;
   localparam logic [CHUNK_SIZE_W-1:0] CHUNK_SIZE_RESET = 32'd67108864;

   // run length limit; the count field covers the whole legal range
   localparam int MAX_RUN       = 64;
   localparam int MAX_RUN_LIMIT = 64;
   localparam int RUN_CNT_W     = $clog2(MAX_RUN_LIMIT + 1);

   // shared divider: dividend as wide as the widest operand, divisor as wide as the chunk size
   localparam int DIVIDEND_W = OFFSET_W;
   localparam int DIVISOR_W  = CHUNK_SIZE_W;
   localparam int STEP_W     = $clog2(DIVIDEND_W + 1);

   // descriptor queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      FRONT_IDLE,
      FRONT_MOD,
      FRONT_BLOCK,
      FRONT_LEFT,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_EMIT
   } back_state_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
      logic [STEP_W-1:0]     steps;
   } div_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [DIVISOR_W-1:0]  remainder;
   } div_rsp_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // one classified extent, ready to be carried out
   typedef struct packed {
      logic [INODE_W-1:0]      inode;
      logic [CHUNK_NUM_W-1:0]  chunk;
      logic [COMPACTION_W-1:0] compaction;
      logic                    first_valid;
      logic [INDEX_W-1:0]      first_index;
      logic [BYTES_W-1:0]      first_bytes;
      logic                    last_valid;
      logic [INDEX_W-1:0]      last_index;
      logic [BYTES_W-1:0]      last_bytes;
      logic [INDEX_W-1:0]      mid_start;
      logic [RUN_CNT_W-1:0]    mid_count;
      logic                    truncated;
   } desc_type;

endpackage

`default_nettype wire

@@ rtl/extent_to_block_splitter.sv @@
// Extent to block splitter, top level. The front holds one extent at a time and takes
// no new one while the shared one-bit-per-cycle divider runs (48 steps for the chunk
// reduction, 32 each for the block split and, for a longer extent only, the remainder)
// or while the queue is full. Requests of an extent leave at one per cycle while the
// result register is popped. Synchronous reset clears queues and handshakes;
// configuration returns to 4 MiB blocks, 64 MiB chunks, filesystem 0.
`default_nettype none
`include "extent_to_block_splitter_assert.svh"

module extent_to_block_splitter #(
   parameter int MaxRun = ets_pkg::MAX_RUN
) (
   input  wire                               clock,
   input  wire                               reset,
   // configuration writes
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [ets_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [ets_pkg::CSR_DATA_W-1:0]    csr_data,
   // extent input
   input  wire                               req_push,
   output logic                              req_full,
   input  wire  [ets_pkg::INODE_W-1:0]       req_inode_number,
   input  wire  [ets_pkg::CHUNK_NUM_W-1:0]   req_chunk_number,
   input  wire  [ets_pkg::COMPACTION_W-1:0]  req_compaction_version,
   input  wire  [ets_pkg::OFFSET_W-1:0]      req_byte_offset,
   input  wire  [ets_pkg::LENGTH_W-1:0]      req_byte_length,
   // block request output
   output logic                              rsp_empty,
   input  wire                               rsp_pop,
   output logic [ets_pkg::FS_ID_W-1:0]       rsp_key_filesystem,
   output logic [ets_pkg::INODE_W-1:0]       rsp_key_inode,
   output logic [ets_pkg::CHUNK_NUM_W-1:0]   rsp_key_chunk,
   output logic [ets_pkg::INDEX_W-1:0]       rsp_key_block_index,
   output logic [ets_pkg::COMPACTION_W-1:0]  rsp_key_compaction,
   output logic [ets_pkg::BYTES_W-1:0]       rsp_fetch_bytes,
   output logic                              rsp_run_last,
   output logic                              rsp_run_truncated
);
   import ets_pkg::*;

   // Configuration registers. Software must write them only while the block is idle (the
   // block itself does not enforce this), since the front and back read them live.
   logic [BLOCK_SIZE_W-1:0] block_size_ff, block_size_in;
   logic [CHUNK_SIZE_W-1:0] chunk_size_ff, chunk_size_in;
   logic [FS_ID_W-1:0]      filesystem_id_ff, filesystem_id_in;

   // A zero size behaves as one byte.
   logic [BLOCK_SIZE_W-1:0] block_size_eff;
   logic [CHUNK_SIZE_W-1:0] chunk_size_eff;

   // front to queue, queue to back
   logic             q_push;
   logic             q_pop;
   desc_type         q_wr_desc;
   desc_type         q_rd_desc;
   queue_status_type q_status;

   assign csr_ready = 1'b1;

   always_comb begin
      block_size_in    = block_size_ff;
      chunk_size_in    = chunk_size_ff;
      filesystem_id_in = filesystem_id_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BLOCK_SIZE:    block_size_in    = csr_data[BLOCK_SIZE_W-1:0];
            CSR_CHUNK_SIZE:    chunk_size_in    = csr_data[CHUNK_SIZE_W-1:0];
            CSR_FILESYSTEM_ID: filesystem_id_in = csr_data[FS_ID_W-1:0];
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff    <= BLOCK_SIZE_RESET;
         chunk_size_ff    <= CHUNK_SIZE_RESET;
         filesystem_id_ff <= '0;
      end else begin
         block_size_ff    <= block_size_in;
         chunk_size_ff    <= chunk_size_in;
         filesystem_id_ff <= filesystem_id_in;
      end
   end

   assign block_size_eff = (block_size_ff == '0) ? BLOCK_SIZE_W'(1) : block_size_ff;
   assign chunk_size_eff = (chunk_size_ff == '0) ? CHUNK_SIZE_W'(1) : chunk_size_ff;

   // Front: take an extent, reduce the offset into the chunk, split it into
   // block position, first/last partial blocks and a capped middle run.
   ets_front #(
      .MaxRun (MaxRun)
   ) u_front (
      .clock                  (clock),
      .reset                  (reset),
      .blk_bytes              (block_size_eff),
      .chunk_bytes            (chunk_size_eff),
      .req_push               (req_push),
      .req_full               (req_full),
      .req_inode_number       (req_inode_number),
      .req_chunk_number       (req_chunk_number),
      .req_compaction_version (req_compaction_version),
      .req_byte_offset        (req_byte_offset),
      .req_byte_length        (req_byte_length),
      .q_status               (q_status),
      .q_push                 (q_push),
      .q_desc                 (q_wr_desc)
   );

   // Hold classified extents so the divider can start on the next one while
   // the back end is still emitting.
   ets_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_desc (q_wr_desc),
      .pop     (q_pop),
      .rd_desc (q_rd_desc),
      .status  (q_status)
   );

   // Back: one request beat per cycle into the result register; a waiting
   // result stalls only the back end, the front keeps filling the queue.
   ets_back u_back (
      .clock               (clock),
      .reset               (reset),
      .blk_bytes           (block_size_eff),
      .filesystem_id       (filesystem_id_ff),
      .q_status            (q_status),
      .q_desc              (q_rd_desc),
      .q_pop               (q_pop),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_key_filesystem  (rsp_key_filesystem),
      .rsp_key_inode       (rsp_key_inode),
      .rsp_key_chunk       (rsp_key_chunk),
      .rsp_key_block_index (rsp_key_block_index),
      .rsp_key_compaction  (rsp_key_compaction),
      .rsp_fetch_bytes     (rsp_fetch_bytes),
      .rsp_run_last        (rsp_run_last),
      .rsp_run_truncated   (rsp_run_truncated)
   );

   // An accepted extent keeps the front busy while the divider runs.
   `ETS_ASSERT_NEXT(a_front_busy_after_accept, clock, reset, req_push && !req_full, req_full)
   // The front never pushes into a full queue.
   `ETS_ASSERT_IMPLIES(a_push_has_room, clock, reset, q_push, !q_status.full)
   // The back only loads a descriptor that is there.
   `ETS_ASSERT_IMPLIES(a_pop_has_entry, clock, reset, q_pop, !q_status.empty)

endmodule

`default_nettype wire

@@ rtl/ets_divider.sv @@
// Restoring divider, one quotient bit per cycle, quotient and remainder held after done.
// Depends on ets_pkg.
`default_nettype none

module ets_divider (
   input  wire                 clock,
   input  wire                 reset,
   input  ets_pkg::div_cmd_type cmd,
   output ets_pkg::div_rsp_type rsp
);
   import ets_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;

   logic [DIVISOR_W:0] shifted;
   logic [DIVISOR_W:0] diff;
   logic               fits;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign fits    = shifted >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (cmd.start) begin
         busy_in    = 1'b1;
         cnt_in     = cmd.steps;
         quo_in     = cmd.dividend;
         rem_in     = '0;
         divisor_in = cmd.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

`default_nettype wire

@@ rtl/ets_front.sv @@
// Front end: accept an extent, reduce it with the shared divider, classify it into a descriptor.
// Depends on ets_pkg and ets_divider.
`default_nettype none

module ets_front #(
   parameter int MaxRun = ets_pkg::MAX_RUN
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire  [ets_pkg::BLOCK_SIZE_W-1:0]      blk_bytes,
   input  wire  [ets_pkg::CHUNK_SIZE_W-1:0]      chunk_bytes,
   input  wire                                   req_push,
   output logic                                  req_full,
   input  wire  [ets_pkg::INODE_W-1:0]           req_inode_number,
   input  wire  [ets_pkg::CHUNK_NUM_W-1:0]       req_chunk_number,
   input  wire  [ets_pkg::COMPACTION_W-1:0]      req_compaction_version,
   input  wire  [ets_pkg::OFFSET_W-1:0]          req_byte_offset,
   input  wire  [ets_pkg::LENGTH_W-1:0]          req_byte_length,
   input  ets_pkg::queue_status_type             q_status,
   output logic                                  q_push,
   output ets_pkg::desc_type                     q_desc
);
   import ets_pkg::*;

   localparam int MID_W = INDEX_W + 1;
   localparam int PAD_W = DIVIDEND_W - DIVISOR_W;

   front_state_type state_ff, state_in;

   logic [INODE_W-1:0]      inode_ff, inode_in;
   logic [CHUNK_NUM_W-1:0]  chunk_ff, chunk_in;
   logic [COMPACTION_W-1:0] compaction_ff, compaction_in;
   logic [LENGTH_W-1:0]     length_ff, length_in;
   logic [INDEX_W-1:0]      begin_index_ff, begin_index_in;
   logic [BYTES_W-1:0]      block_pos_ff, block_pos_in;
   logic                    short_ff, short_in;
   logic [INDEX_W-1:0]      whole_ff, whole_in;
   logic [BYTES_W-1:0]      last_bytes_ff, last_bytes_in;

   div_cmd_type div_cmd;
   div_rsp_type div_rsp;

   logic                accept;
   logic                is_short;
   logic [BYTES_W-1:0]  lead_bytes;
   logic [LENGTH_W-1:0] left_bytes;

   ets_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   assign accept = req_push && !req_full;

   // classify once the block position is known
   assign is_short   = length_ff < LENGTH_W'(blk_bytes);
   assign lead_bytes = (div_rsp.remainder[BYTES_W-1:0] != '0)
                       ? blk_bytes - div_rsp.remainder[BYTES_W-1:0] : blk_bytes;
   assign left_bytes = length_ff - LENGTH_W'(lead_bytes);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FRONT_IDLE:  if (accept) state_in = FRONT_MOD;
         FRONT_MOD:   if (div_rsp.done) state_in = FRONT_BLOCK;
         FRONT_BLOCK: if (div_rsp.done) state_in = is_short ? FRONT_PUSH : FRONT_LEFT;
         FRONT_LEFT:  if (div_rsp.done) state_in = FRONT_PUSH;
         FRONT_PUSH:  if (!q_status.full) state_in = FRONT_IDLE;
         default:     state_in = FRONT_IDLE;
      endcase
   end

   // outputs: divider commands and queue push
   always_comb begin
      req_full         = state_ff != FRONT_IDLE;
      q_push           = 1'b0;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = DIVIDEND_W'(req_byte_offset);
      div_cmd.divisor  = chunk_bytes;
      div_cmd.steps    = STEP_W'(DIVIDEND_W);
      case (state_ff)
         FRONT_IDLE: begin
            div_cmd.start = accept;
         end
         FRONT_MOD: begin
            div_cmd.start    = div_rsp.done;
            div_cmd.dividend = {div_rsp.remainder, PAD_W'(0)};
            div_cmd.divisor  = DIVISOR_W'(blk_bytes);
            div_cmd.steps    = STEP_W'(DIVISOR_W);
         end
         FRONT_BLOCK: begin
            div_cmd.start    = div_rsp.done && !is_short;
            div_cmd.dividend = {DIVISOR_W'(left_bytes), PAD_W'(0)};
            div_cmd.divisor  = DIVISOR_W'(blk_bytes);
            div_cmd.steps    = STEP_W'(DIVISOR_W);
         end
         FRONT_PUSH: begin
            q_push = !q_status.full;
         end
         default: ;
      endcase
   end

   // datapath captures
   always_comb begin
      inode_in       = inode_ff;
      chunk_in       = chunk_ff;
      compaction_in  = compaction_ff;
      length_in      = length_ff;
      begin_index_in = begin_index_ff;
      block_pos_in   = block_pos_ff;
      short_in       = short_ff;
      whole_in       = whole_ff;
      last_bytes_in  = last_bytes_ff;
      case (state_ff)
         FRONT_IDLE: begin
            if (accept) begin
               inode_in      = req_inode_number;
               chunk_in      = req_chunk_number;
               compaction_in = req_compaction_version;
               length_in     = req_byte_length;
            end
         end
         FRONT_BLOCK: begin
            if (div_rsp.done) begin
               begin_index_in = div_rsp.quotient[INDEX_W-1:0];
               block_pos_in   = div_rsp.remainder[BYTES_W-1:0];
               short_in       = is_short;
            end
         end
         FRONT_LEFT: begin
            if (div_rsp.done) begin
               whole_in      = div_rsp.quotient[INDEX_W-1:0];
               last_bytes_in = div_rsp.remainder[BYTES_W-1:0];
            end
         end
         default: ;
      endcase
   end

   // descriptor built from the captured quotients
   always_comb begin
      logic                 first_part;
      logic                 last_part;
      logic [MID_W-1:0]     middle;
      logic [MID_W:0]       total;
      logic [RUN_CNT_W-1:0] room;
      first_part = block_pos_ff != '0;
      last_part  = !short_ff && (last_bytes_ff != '0);
      middle     = short_ff ? '0 : ({1'b0, whole_ff} + MID_W'(!first_part));
      total      = {1'b0, middle} + (MID_W+1)'(first_part) + (MID_W+1)'(last_part);
      room       = RUN_CNT_W'(MaxRun) - RUN_CNT_W'(first_part) - RUN_CNT_W'(last_part);

      q_desc.inode       = inode_ff;
      q_desc.chunk       = chunk_ff;
      q_desc.compaction  = compaction_ff;
      q_desc.first_valid = short_ff || first_part;
      q_desc.first_index = begin_index_ff;
      q_desc.first_bytes = short_ff ? length_ff[BYTES_W-1:0]
                         : (first_part ? blk_bytes - block_pos_ff : blk_bytes);
      q_desc.last_valid  = last_part;
      q_desc.last_index  = begin_index_ff + whole_ff + INDEX_W'(1);
      q_desc.last_bytes  = last_bytes_ff;
      q_desc.mid_start   = begin_index_ff + INDEX_W'(first_part);
      q_desc.mid_count   = (middle > MID_W'(room)) ? room : middle[RUN_CNT_W-1:0];
      q_desc.truncated   = !short_ff && (total > (MID_W+1)'(MaxRun));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      inode_ff       <= inode_in;
      chunk_ff       <= chunk_in;
      compaction_ff  <= compaction_in;
      length_ff      <= length_in;
      begin_index_ff <= begin_index_in;
      block_pos_ff   <= block_pos_in;
      short_ff       <= short_in;
      whole_ff       <= whole_in;
      last_bytes_ff  <= last_bytes_in;
   end

endmodule

`default_nettype wire

@@ rtl/ets_queue.sv @@
// Short descriptor queue that decouples the front end from the request emitter.
// Depends on ets_pkg.
`default_nettype none

module ets_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  ets_pkg::desc_type         wr_desc,
   input  wire                       pop,
   output ets_pkg::desc_type         rd_desc,
   output ets_pkg::queue_status_type status
);
   import ets_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   desc_type entries_ff [QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= wr_desc;
      end
   end

   assign rd_desc      = entries_ff[rd_ptr_ff];
   assign status.empty = count_ff == '0;
   assign status.full  = count_ff == CNT_W'(QUEUE_DEPTH);

endmodule

`default_nettype wire

@@ rtl/ets_back.sv @@
// Back end: walk one descriptor and emit its block requests into the result register.
// Depends on ets_pkg.
`default_nettype none

module ets_back (
   input  wire                               clock,
   input  wire                               reset,
   input  wire  [ets_pkg::BLOCK_SIZE_W-1:0]  blk_bytes,
   input  wire  [ets_pkg::FS_ID_W-1:0]       filesystem_id,
   input  ets_pkg::queue_status_type         q_status,
   input  ets_pkg::desc_type                 q_desc,
   output logic                              q_pop,
   output logic                              rsp_empty,
   input  wire                               rsp_pop,
   output logic [ets_pkg::FS_ID_W-1:0]       rsp_key_filesystem,
   output logic [ets_pkg::INODE_W-1:0]       rsp_key_inode,
   output logic [ets_pkg::CHUNK_NUM_W-1:0]   rsp_key_chunk,
   output logic [ets_pkg::INDEX_W-1:0]       rsp_key_block_index,
   output logic [ets_pkg::COMPACTION_W-1:0]  rsp_key_compaction,
   output logic [ets_pkg::BYTES_W-1:0]       rsp_fetch_bytes,
   output logic                              rsp_run_last,
   output logic                              rsp_run_truncated
);
   import ets_pkg::*;

   back_state_type state_ff, state_in;
   desc_type       cur_ff, cur_in;

   logic                    out_valid_ff, out_valid_in;
   logic [FS_ID_W-1:0]      out_fs_ff, out_fs_in;
   logic [INODE_W-1:0]      out_inode_ff, out_inode_in;
   logic [CHUNK_NUM_W-1:0]  out_chunk_ff, out_chunk_in;
   logic [INDEX_W-1:0]      out_index_ff, out_index_in;
   logic [COMPACTION_W-1:0] out_compaction_ff, out_compaction_in;
   logic [BYTES_W-1:0]      out_bytes_ff, out_bytes_in;
   logic                    out_last_ff, out_last_in;
   logic                    out_trunc_ff, out_trunc_in;

   logic                 advance;
   logic                 emit;
   logic [RUN_CNT_W:0]   pending;
   logic                 final_req;

   assign advance   = !out_valid_ff || rsp_pop;
   assign pending   = (RUN_CNT_W+1)'(cur_ff.first_valid) + (RUN_CNT_W+1)'(cur_ff.last_valid)
                    + (RUN_CNT_W+1)'(cur_ff.mid_count);
   assign final_req = pending == (RUN_CNT_W+1)'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: if (!q_status.empty) state_in = BACK_EMIT;
         BACK_EMIT: if (advance && final_req) state_in = BACK_IDLE;
         default:   state_in = BACK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop = 1'b0;
      emit  = 1'b0;
      case (state_ff)
         BACK_IDLE: q_pop = !q_status.empty;
         BACK_EMIT: emit = advance;
         default: ;
      endcase
   end

   // pick first, then last, then the middle blocks in ascending order
   always_comb begin
      cur_in            = cur_ff;
      out_fs_in         = out_fs_ff;
      out_inode_in      = out_inode_ff;
      out_chunk_in      = out_chunk_ff;
      out_index_in      = out_index_ff;
      out_compaction_in = out_compaction_ff;
      out_bytes_in      = out_bytes_ff;
      out_last_in       = out_last_ff;
      out_trunc_in      = out_trunc_ff;
      out_valid_in      = (out_valid_ff && !rsp_pop) || emit;
      if (q_pop) begin
         cur_in = q_desc;
      end
      if (emit) begin
         out_fs_in         = filesystem_id;
         out_inode_in      = cur_ff.inode;
         out_chunk_in      = cur_ff.chunk;
         out_compaction_in = cur_ff.compaction;
         out_last_in       = final_req;
         out_trunc_in      = cur_ff.truncated;
         if (cur_ff.first_valid) begin
            out_index_in       = cur_ff.first_index;
            out_bytes_in       = cur_ff.first_bytes;
            cur_in.first_valid = 1'b0;
         end else if (cur_ff.last_valid) begin
            out_index_in      = cur_ff.last_index;
            out_bytes_in      = cur_ff.last_bytes;
            cur_in.last_valid = 1'b0;
         end else begin
            out_index_in     = cur_ff.mid_start;
            out_bytes_in     = blk_bytes;
            cur_in.mid_start = cur_ff.mid_start + INDEX_W'(1);
            cur_in.mid_count = cur_ff.mid_count - RUN_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff            <= cur_in;
      out_fs_ff         <= out_fs_in;
      out_inode_ff      <= out_inode_in;
      out_chunk_ff      <= out_chunk_in;
      out_index_ff      <= out_index_in;
      out_compaction_ff <= out_compaction_in;
      out_bytes_ff      <= out_bytes_in;
      out_last_ff       <= out_last_in;
      out_trunc_ff      <= out_trunc_in;
   end

   assign rsp_empty           = !out_valid_ff;
   assign rsp_key_filesystem  = out_fs_ff;
   assign rsp_key_inode       = out_inode_ff;
   assign rsp_key_chunk       = out_chunk_ff;
   assign rsp_key_block_index = out_index_ff;
   assign rsp_key_compaction  = out_compaction_ff;
   assign rsp_fetch_bytes     = out_bytes_ff;
   assign rsp_run_last        = out_last_ff;
   assign rsp_run_truncated   = out_trunc_ff;

endmodule

`default_nettype wire
